/* rtl/decimal_length_frame_parser_unit_defines.svh */
// Assertion macros shared by the frame parser RTL.
// Included by every module that carries concurrent assertions; depends on nothing.
`ifndef DECIMAL_LENGTH_FRAME_PARSER_UNIT_DEFINES_SVH
`define DECIMAL_LENGTH_FRAME_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked assertion that is switched off while reset is asserted.
`define DLFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DLFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DLFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define DLFP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/dlfp_pkg.sv */
// Shared types and constants of the decimal length frame parser.
// No dependencies; every other file of the block but the assertion macro header imports it.
`timescale 1ns / 1ps

package dlfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 30;
    localparam int FIELD_W     = 4;
    localparam int FIELD_LIMIT = 15;
    localparam int CFG_INDEX_W = 2;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'd57;

    localparam logic [BYTE_W-1:0] ENDPOINT_SEP_RESET = 8'd58;
    localparam logic [BYTE_W-1:0] ARGUMENT_SEP_RESET = 8'd44;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ENDPOINT_SEP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ARGUMENT_SEP = 2'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] endpoint;
        logic [BYTE_W-1:0] argument;
    } t_seps;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] in_byte;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic [FIELD_W-1:0] field_number;
        logic               is_separator;
        logic               empty_frame;
        logic               frame_last;
        logic               header_error;
    } t_result;

endpackage

/* rtl/dlfp_byte_if.sv */
// Input byte stream channel of the frame parser.
// Depends on dlfp_pkg for the byte width.
`timescale 1ns / 1ps

interface dlfp_byte_if import dlfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

/* rtl/dlfp_result_if.sv */
// Result channel of the frame parser: one tagged body byte or empty-frame mark per beat.
// Depends on dlfp_pkg for the field widths.
`timescale 1ns / 1ps

interface dlfp_result_if import dlfp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  data_byte;
    logic [FIELD_W-1:0] field_number;
    logic               is_separator;
    logic               empty_frame;
    logic               frame_last;
    logic               header_error;

    modport source (output valid, output data_byte, output field_number, output is_separator,
                    output empty_frame, output frame_last, output header_error, input ready);
    modport sink   (input valid, input data_byte, input field_number, input is_separator,
                    input empty_frame, input frame_last, input header_error, output ready);
endinterface

/* rtl/dlfp_cfg_if.sv */
// Configuration write channel of the frame parser.
// Depends on dlfp_pkg for the index and data widths.
`timescale 1ns / 1ps

interface dlfp_cfg_if import dlfp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/dlfp_cfg_regs.sv */
// Separator configuration registers of the frame parser.
// Depends on dlfp_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module dlfp_cfg_regs import dlfp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [CFG_INDEX_W-1:0] i_index,
    input  logic [BYTE_W-1:0]      i_data,
    output logic                   o_ready,
    output t_seps                  o_seps
);

    t_seps r_seps;
    t_seps n_seps;

    assign o_ready = 1'b1;
    assign o_seps  = r_seps;

    always_comb begin
        n_seps = r_seps;
        if (i_valid) begin
            // Writes to unknown indexes are dropped.
            unique case (i_index)
                CFG_ENDPOINT_SEP: n_seps.endpoint = i_data;
                CFG_ARGUMENT_SEP: n_seps.argument = i_data;
                default:          n_seps = r_seps;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seps.endpoint <= ENDPOINT_SEP_RESET;
            r_seps.argument <= ARGUMENT_SEP_RESET;
        end else begin
            r_seps <= n_seps;
        end
    end

endmodule

/* rtl/dlfp_in_stage.sv */
// Input register of the frame parser: holds one accepted byte until the core takes it.
// Depends on dlfp_pkg for the beat type.
`timescale 1ns / 1ps

module dlfp_in_stage import dlfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_ready,
    input  logic              i_adv,
    output t_in_beat          o_beat
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              accept;

    assign o_ready = !r_valid || i_adv;
    assign accept  = i_valid && o_ready;

    assign o_beat.valid   = r_valid;
    assign o_beat.in_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte;
        end
    end

endmodule

/* rtl/dlfp_core.sv */
// Frame parsing core: header accumulation, body countdown, field tagging and result register.
// Depends on dlfp_pkg and the assertion macros in decimal_length_frame_parser_unit_defines.svh.
`timescale 1ns / 1ps
`include "decimal_length_frame_parser_unit_defines.svh"

module dlfp_core import dlfp_pkg::*; #(
    parameter int HEADER_DIGITS = 4,
    parameter int MAX_FIELDS    = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_beat i_beat,
    output logic     o_adv,
    input  t_seps    i_seps,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output t_result  o_result
);

    localparam int HDR_CNT_W = $clog2(HEADER_DIGITS + 1);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_DIGITS - 1);
    localparam logic [FIELD_W-1:0] FIELD_TOP =
        FIELD_W'(((MAX_FIELDS - 1) > FIELD_LIMIT) ? FIELD_LIMIT : (MAX_FIELDS - 1));
    localparam logic [FIELD_W-1:0] FIELD_AFTER_EP = FIELD_W'((FIELD_TOP >= 1) ? 1 : 0);

    logic                 r_in_body,  n_in_body;
    logic [HDR_CNT_W-1:0] r_hdr_cnt,  n_hdr_cnt;
    // Holds the length while the header is read, then counts body bytes down.
    logic [LEN_W-1:0]     r_count,    n_count;
    logic [FIELD_W-1:0]   r_field,    n_field;
    logic                 r_stopped,  n_stopped;
    logic                 r_out_valid;
    t_result              r_result;

    logic [BYTE_W-1:0]    b;
    logic                 digit;
    logic [BYTE_W-1:0]    digit_val;
    logic [LEN_W-1:0]     count_x10;
    logic [LEN_W-1:0]     header_len;
    logic                 hdr_stop;
    logic                 body_last;
    logic                 emit;
    t_result              res;

    assign b     = i_beat.in_byte;
    assign o_adv = i_beat.valid && (!r_out_valid || i_out_ready);

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        digit      = !r_stopped && (b >= ASCII_ZERO) && (b <= ASCII_NINE);
        digit_val  = b - ASCII_ZERO;
        count_x10  = (r_count << 3) + (r_count << 1) + LEN_W'(digit_val[3:0]);
        header_len = digit ? count_x10 : r_count;
        hdr_stop   = r_stopped || !digit;
        body_last  = (r_count == LEN_W'(1));

        n_in_body = r_in_body;
        n_hdr_cnt = r_hdr_cnt;
        n_count   = r_count;
        n_field   = r_field;
        n_stopped = r_stopped;
        emit      = 1'b0;
        res       = '0;

        if (!r_in_body) begin
            if (r_hdr_cnt != HDR_LAST) begin
                n_count   = header_len;
                n_stopped = hdr_stop;
                n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
            end else if (header_len == '0) begin
                emit             = 1'b1;
                res.empty_frame  = 1'b1;
                res.frame_last   = 1'b1;
                res.header_error = hdr_stop;
                n_hdr_cnt        = '0;
                n_count          = '0;
                n_field          = '0;
                n_stopped        = 1'b0;
            end else begin
                n_in_body = 1'b1;
                n_count   = header_len;
                n_stopped = hdr_stop;
                n_hdr_cnt = '0;
                n_field   = '0;
            end
        end else begin
            emit             = 1'b1;
            res.data_byte    = b;
            res.field_number = r_field;
            res.header_error = r_stopped;
            res.frame_last   = body_last;
            n_count          = r_count - LEN_W'(1);
            // Only the first endpoint separator counts; afterwards the argument one does.
            if (r_field == '0) begin
                if (b == i_seps.endpoint) begin
                    res.is_separator = 1'b1;
                    n_field          = FIELD_AFTER_EP;
                end
            end else if (b == i_seps.argument) begin
                res.is_separator = 1'b1;
                if (r_field < FIELD_TOP) begin
                    n_field = r_field + FIELD_W'(1);
                end
            end
            if (body_last) begin
                n_in_body = 1'b0;
                n_field   = '0;
                n_stopped = 1'b0;
                n_count   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body <= 1'b0;
            r_hdr_cnt <= '0;
            r_count   <= '0;
            r_field   <= '0;
            r_stopped <= 1'b0;
        end else if (o_adv) begin
            r_in_body <= n_in_body;
            r_hdr_cnt <= n_hdr_cnt;
            r_count   <= n_count;
            r_field   <= n_field;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && emit) begin
            r_result <= res;
        end
    end

    `DLFP_ASSERT(a_body_count_nonzero, i_clk, i_rst_n, r_in_body |-> (r_count != '0), "body count reached zero inside a body")
    `DLFP_ASSERT(a_field_saturates, i_clk, i_rst_n, r_field <= FIELD_TOP, "field number passed its top")
    `DLFP_ASSERT(a_empty_shape, i_clk, i_rst_n, (r_out_valid && r_result.empty_frame) |-> (r_result.frame_last && (r_result.field_number == '0) && !r_result.is_separator), "malformed empty-frame result")
    `DLFP_ASSERT(a_last_restarts, i_clk, i_rst_n, (o_adv && emit && res.frame_last) |=> (!r_in_body && (r_count == '0) && (r_hdr_cnt == '0) && !r_stopped), "frame end did not restart header")

endmodule

/* rtl/decimal_length_frame_parser_unit.sv */
// Top level of the decimal length frame parser: channels, configuration and parsing core.
// Depends on dlfp_pkg, the three channel interfaces, dlfp_cfg_regs, dlfp_in_stage and dlfp_core.
`timescale 1ns / 1ps

// The parser takes one stream byte per clock and keeps that rate for as long as the result
// channel keeps taking beats. Each frame opens with HEADER_DIGITS ASCII decimal bytes that
// give the body length; parsing stops at the first non-digit, which flags header_error on
// every result of that frame. Every body byte comes out as one result tagged with its field
// number (field 0 up to the first endpoint separator, then one more field per argument
// separator, saturating at the smaller of MAX_FIELDS-1 and 15); a zero length gives one
// empty_frame result. A byte passes from the input register, where the header and field
// logic works on it, into the result register when the core advances.
// A stalled result channel holds the output beat and the input register still takes one more
// byte. Separators may only be rewritten while the parser is idle.
module decimal_length_frame_parser_unit import dlfp_pkg::*; #(
    parameter int HEADER_DIGITS = 4,
    parameter int MAX_FIELDS    = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dlfp_byte_if.sink       i_in,
    dlfp_cfg_if.sink        i_cfg,
    dlfp_result_if.source   o_out
);

    t_seps    seps;
    t_in_beat beat;
    t_result  result;
    logic     adv;
    logic     out_valid;

    dlfp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_ready (i_cfg.ready),
        .o_seps  (seps)
    );

    dlfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.in_byte),
        .o_ready (i_in.ready),
        .i_adv   (adv),
        .o_beat  (beat)
    );

    dlfp_core #(
        .HEADER_DIGITS (HEADER_DIGITS),
        .MAX_FIELDS    (MAX_FIELDS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .o_adv       (adv),
        .i_seps      (seps),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign o_out.valid        = out_valid;
    assign o_out.data_byte    = result.data_byte;
    assign o_out.field_number = result.field_number;
    assign o_out.is_separator = result.is_separator;
    assign o_out.empty_frame  = result.empty_frame;
    assign o_out.frame_last   = result.frame_last;
    assign o_out.header_error = result.header_error;

endmodule

/* sim/dlfp_frame_checker.sv */
// Scoreboard for the decimal length frame parser: watches the byte, result and configuration
// channels, predicts every result beat and compares it field by field.
// Depends on dlfp_pkg and the three channel interfaces.
`timescale 1ns / 1ps

module dlfp_frame_checker import dlfp_pkg::*; #(
    parameter int HEADER_DIGITS = 4,
    parameter int MAX_FIELDS    = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dlfp_byte_if    i_in,
    dlfp_cfg_if     i_cfg,
    dlfp_result_if  i_res,
    output int      o_fail_count,
    output int      o_pending
);

    localparam int TOP_FIELD_INT = (MAX_FIELDS - 1 > FIELD_LIMIT) ? FIELD_LIMIT : MAX_FIELDS - 1;
    localparam logic [FIELD_W-1:0] TOP_FIELD = FIELD_W'(TOP_FIELD_INT);

    t_seps              seps;
    logic               body_active;
    logic [3:0]         header_bytes_seen;
    logic [LEN_W-1:0]   frame_length;
    logic [LEN_W-1:0]   body_left;
    logic [FIELD_W-1:0] field_now;
    logic               header_bad;
    t_result            expected_results [$];
    int                 mismatch_count = 0;

    function automatic void clear_frame();
        body_active       = 1'b0;
        header_bytes_seen = '0;
        frame_length      = '0;
        body_left         = '0;
        field_now         = '0;
        header_bad        = 1'b0;
    endfunction

    // Advances the parser state by one stream byte; returns 1 when the byte yields a result.
    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output t_result res);
        res = '0;
        if (!body_active) begin
            // Once a non-digit shows up, the rest of the header is skipped, digits included.
            if (!header_bad && b >= ASCII_ZERO && b <= ASCII_NINE) begin
                frame_length = LEN_W'(frame_length * 10) + LEN_W'(b - ASCII_ZERO);
            end else begin
                header_bad = 1'b1;
            end
            header_bytes_seen = header_bytes_seen + 1'b1;
            if (header_bytes_seen < HEADER_DIGITS)
                return 1'b0;
            if (frame_length == '0) begin
                res.empty_frame  = 1'b1;
                res.frame_last   = 1'b1;
                res.header_error = header_bad;
                clear_frame();
                return 1'b1;
            end
            body_active = 1'b1;
            body_left   = frame_length;
            field_now   = '0;
            return 1'b0;
        end

        res.data_byte    = b;
        res.field_number = field_now;
        res.header_error = header_bad;
        if (field_now == '0) begin
            if (b == seps.endpoint) begin
                res.is_separator = 1'b1;
                field_now        = FIELD_W'(1);
            end
        end else if (b == seps.argument) begin
            res.is_separator = 1'b1;
            if (field_now < TOP_FIELD)
                field_now = field_now + 1'b1;
        end
        body_left      = body_left - 1'b1;
        res.frame_last = (body_left == '0);
        if (res.frame_last)
            clear_frame();
        return 1'b1;
    endfunction

    task automatic check_field(input string field_name, input logic [BYTE_W-1:0] want_v,
                               input logic [BYTE_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", field_name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        t_result predicted;
        if (!i_rst_n) begin
            seps.endpoint = ENDPOINT_SEP_RESET;
            seps.argument = ARGUMENT_SEP_RESET;
            clear_frame();
            expected_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                seen.data_byte    = i_res.data_byte;
                seen.field_number = i_res.field_number;
                seen.is_separator = i_res.is_separator;
                seen.empty_frame  = i_res.empty_frame;
                seen.frame_last   = i_res.frame_last;
                seen.header_error = i_res.header_error;
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected: data_byte %0d", seen.data_byte);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("data_byte", want.data_byte, seen.data_byte);
                    check_field("field_number", BYTE_W'(want.field_number),
                                BYTE_W'(seen.field_number));
                    check_field("is_separator", BYTE_W'(want.is_separator),
                                BYTE_W'(seen.is_separator));
                    check_field("empty_frame", BYTE_W'(want.empty_frame),
                                BYTE_W'(seen.empty_frame));
                    check_field("frame_last", BYTE_W'(want.frame_last),
                                BYTE_W'(seen.frame_last));
                    check_field("header_error", BYTE_W'(want.header_error),
                                BYTE_W'(seen.header_error));
                end
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_ENDPOINT_SEP: seps.endpoint = i_cfg.data;
                    CFG_ARGUMENT_SEP: seps.argument = i_cfg.data;
                    default: ;  // Writes to unused indexes are dropped.
                endcase
            end

            if (i_in.valid && i_in.ready) begin
                if (parse_byte(i_in.in_byte, predicted))
                    expected_results.push_back(predicted);
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = mismatch_count;
    end

endmodule

/* sim/tb_decimal_length_frame_parser_unit.sv */
// Top of the frame parser testbench: clock, reset, byte and configuration stimulus, result
// back-pressure and the verdict. Depends on dlfp_pkg, the channel interfaces, the parser RTL
// and dlfp_frame_checker.
`timescale 1ns / 1ps

module tb_decimal_length_frame_parser_unit;
    import dlfp_pkg::*;

    localparam int HDR_DIGITS    = 4;
    localparam int FIELD_COUNT   = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_BYTES   = 150;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HIGH = 2'd3;

    typedef logic [BYTE_W-1:0] t_header [HDR_DIGITS];

    logic i_clk;
    logic i_rst_n;

    dlfp_byte_if   byte_ch ();
    dlfp_cfg_if    cfg_ch ();
    dlfp_result_if res_ch ();

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int phase_bytes   = 0;

    logic [BYTE_W-1:0] ep_sep  = ENDPOINT_SEP_RESET;
    logic [BYTE_W-1:0] arg_sep = ARGUMENT_SEP_RESET;
    logic [BYTE_W-1:0] directed_stream [$];

    decimal_length_frame_parser_unit #(
        .HEADER_DIGITS (HDR_DIGITS),
        .MAX_FIELDS    (FIELD_COUNT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    dlfp_frame_checker #(
        .HEADER_DIGITS (HDR_DIGITS),
        .MAX_FIELDS    (FIELD_COUNT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (byte_ch),
        .i_cfg        (cfg_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Ends the run when no beat moves on any channel for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_decimal_length_frame_parser_unit: done, errors");
        $finish;
    end

    function automatic int hdr_value(input t_header hdr);
        int val = 0;
        for (int k = 0; k < HDR_DIGITS; k++) begin
            if (hdr[k] < ASCII_ZERO || hdr[k] > ASCII_NINE)
                return val;
            val = val * 10 + int'(hdr[k] - ASCII_ZERO);
        end
        return val;
    endfunction

    function automatic t_header make_header(input int len);
        t_header hdr;
        for (int k = HDR_DIGITS - 1; k >= 0; k--) begin
            hdr[k] = ASCII_ZERO + BYTE_W'(len % 10);
            len = len / 10;
        end
        return hdr;
    endfunction

    // Picks a non-digit, favoring the characters that atoi would treat specially.
    function automatic logic [BYTE_W-1:0] non_digit();
        logic [BYTE_W-1:0] b;
        case ($urandom_range(5))
            0: b = " ";
            1: b = "-";
            2: b = "+";
            3: b = ASCII_ZERO - 1'b1;
            4: b = ASCII_NINE + 1'b1;
            default: begin
                do b = BYTE_W'($urandom_range(255)); while (b >= ASCII_ZERO && b <= ASCII_NINE);
            end
        endcase
        return b;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do @(negedge i_clk); while (!byte_ch.ready);
        @(posedge i_clk);
        phase_bytes++;
    endtask

    // Shaped bodies follow the field layout: the endpoint separator once, then argument
    // separators, with an occasional separator of the wrong kind mixed in.
    task automatic send_frame(input t_header hdr, input int sep_pct, input bit shaped);
        int len;
        int pick;
        bit ep_done;
        logic [BYTE_W-1:0] b;
        len     = hdr_value(hdr);
        ep_done = 1'b0;
        for (int k = 0; k < HDR_DIGITS; k++)
            send_byte(hdr[k]);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(99);
            if (shaped && pick < sep_pct) begin
                b       = ep_done ? arg_sep : ep_sep;
                ep_done = 1'b1;
            end else if (shaped && pick < sep_pct + 5) begin
                b = ep_done ? ep_sep : arg_sep;
            end else begin
                b = BYTE_W'($urandom_range(255));
            end
            send_byte(b);
        end
    endtask

    task automatic send_random_frame();
        t_header hdr;
        int kind;
        int len;
        kind = $urandom_range(99);
        len  = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(1, 24);
        hdr  = make_header(len);
        if (kind < 60) begin
            send_frame(hdr, 15, 1'b1);
        end else if (kind < 70) begin
            // Dense argument separators push the field number into saturation.
            send_frame(make_header($urandom_range(30, 45)), 60, 1'b1);
        end else if (kind < 85) begin
            hdr[$urandom_range(HDR_DIGITS - 1)] = non_digit();
            send_frame(hdr, 15, 1'b1);
        end else begin
            do begin
                foreach (hdr[k])
                    hdr[k] = $urandom_range(1) ? ASCII_ZERO + BYTE_W'($urandom_range(9))
                                               : BYTE_W'($urandom_range(255));
            end while (hdr_value(hdr) > 60);
            send_frame(hdr, 0, 1'b0);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(negedge i_clk); while (!cfg_ch.ready);
        @(posedge i_clk);
        if (idx == CFG_ENDPOINT_SEP)
            ep_sep = data;
        else if (idx == CFG_ARGUMENT_SEP)
            arg_sep = data;
    endtask

    task automatic set_seps(input logic [BYTE_W-1:0] ep, input logic [BYTE_W-1:0] arg,
                            input logic [CFG_INDEX_W-1:0] spare);
        write_reg(CFG_ENDPOINT_SEP, ep);
        write_reg(spare, BYTE_W'($urandom_range(255)));
        write_reg(CFG_ARGUMENT_SEP, arg);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input int idle_pct, input int stall, input bit with_pressure);
        bit held;
        bit paused;
        held          = 1'b0;
        paused        = 1'b0;
        send_idle_pct = idle_pct;
        stall_pct    <= stall;
        phase_bytes   = 0;
        while (phase_bytes < PHASE_BYTES) begin
            send_random_frame();
            if (with_pressure && !held && phase_bytes > PHASE_BYTES / 3) begin
                held = 1'b1;
                hold_requests <= hold_requests + 1;
            end else if (with_pressure && !paused && phase_bytes > 2 * PHASE_BYTES / 3) begin
                paused = 1'b1;
                byte_ch.valid <= 1'b0;
                wait_drained();
            end
        end
        byte_ch.valid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_ENDPOINT_SEP;
        cfg_ch.data     <= '0;
        i_rst_n         <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short directed stream at the reset separators: an empty frame, separators of both
        // kinds in and out of place with the byte extremes, a sign in the header and a space
        // that cuts the length short.
        directed_stream = '{"0", "0", "0", "0",
                            "0", "0", "0", "7", 8'h00, ARGUMENT_SEP_RESET, ENDPOINT_SEP_RESET,
                            ENDPOINT_SEP_RESET, ARGUMENT_SEP_RESET, 8'hFF, ARGUMENT_SEP_RESET,
                            "-", "0", "1", "2",
                            "1", " ", "2", "3", "x"};
        foreach (directed_stream[k])
            send_byte(directed_stream[k]);
        byte_ch.valid <= 1'b0;
        wait_drained();

        set_seps(ENDPOINT_SEP_RESET, ARGUMENT_SEP_RESET, CFG_SPARE_LOW);
        run_phase(0, 0, 1'b1);

        set_seps(8'h00, 8'hFF, CFG_SPARE_HIGH);
        run_phase(87, 0, 1'b0);

        set_seps(8'hFF, 8'h00, CFG_SPARE_LOW);
        run_phase(0, 87, 1'b0);

        // Equal separators: the same byte ends the endpoint and then splits arguments.
        begin
            logic [BYTE_W-1:0] same;
            same = BYTE_W'($urandom_range(255));
            set_seps(same, same, CFG_SPARE_HIGH);
        end
        run_phase(32, 32, 1'b0);

        set_seps(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), CFG_SPARE_LOW);
        run_phase(32, 32, 1'b0);

        // One longer frame with a two-digit length back at the reset separators.
        set_seps(ENDPOINT_SEP_RESET, ARGUMENT_SEP_RESET, CFG_SPARE_HIGH);
        send_idle_pct = 0;
        stall_pct    <= 0;
        send_frame(make_header(99), 5, 1'b1);
        byte_ch.valid <= 1'b0;
        wait_drained();

        if (fail_count == 0 && pending == 0)
            $display("tb_decimal_length_frame_parser_unit: done, clean");
        else
            $display("tb_decimal_length_frame_parser_unit: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/dlfp_pkg.sv
rtl/dlfp_byte_if.sv
rtl/dlfp_result_if.sv
rtl/dlfp_cfg_if.sv
rtl/dlfp_cfg_regs.sv
rtl/dlfp_in_stage.sv
rtl/dlfp_core.sv
rtl/decimal_length_frame_parser_unit.sv
sim/dlfp_frame_checker.sv
sim/tb_decimal_length_frame_parser_unit.sv
